// File: design/community_set_masked_match_defines.svh
// Assertion macros for the community set masked match block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COMMUNITY_SET_MASKED_MATCH_DEFINES_SVH
`define COMMUNITY_SET_MASKED_MATCH_DEFINES_SVH

// cond must hold at every edge out of reset
`define CSM_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/csm_pkg.sv
// Shared types and constants for the community set masked match block.
// No dependencies.
`default_nettype none

package csm_pkg;

  localparam int DEF_SET_DEPTH = 64;
  localparam int FIELD_W       = 16;
  localparam int HASH_W        = 32;
  localparam int HASH_SHIFT    = 5;
  localparam int CNT_OUT_W     = 7;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 48;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_MATCH  = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] entry_asn;
    logic [FIELD_W-1:0] entry_value;
    logic               use_asn;
    logic               use_value;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic                 dropped;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [HASH_W-1:0]    set_hash;
  } res_t;

endpackage

`default_nettype wire

// File: design/csm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/csm_core.sv
// Request sequencer: clear, insert, summary reject and entry scan.
// Depends on csm_pkg; drives the entry store RAM through its ports.
`default_nettype none

module csm_core
  import csm_pkg::*;
#(
  parameter int SET_DEPTH = DEF_SET_DEPTH,
  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
  localparam int CW = $clog2(SET_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_t                 req,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [2*FIELD_W-1:0]      wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire logic [2*FIELD_W-1:0] rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(SET_DEPTH);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [FIELD_W-1:0] asn_sum_r, asn_sum_nxt;
  logic [FIELD_W-1:0] val_sum_r, val_sum_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r, res_nxt;
  logic [FIELD_W-1:0] q_asn_r, q_val_r;
  logic               q_use_asn_r, q_use_val_r;
  logic               req_fire;
  logic               reject;
  logic               hit;
  logic [HASH_W-1:0]  mix;

  assign req_ready = (state_r == ST_IDLE) && (!res_valid_r || res_ready);
  assign req_fire  = req_valid && req_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign mix    = HASH_W'(req.entry_asn | req.entry_value);
  assign reject = (req.use_asn && ((asn_sum_r & req.entry_asn) == '0)) ||
                  (req.use_value && ((val_sum_r & req.entry_value) == '0));
  assign hit    = (!q_use_asn_r || (rd_data[2*FIELD_W-1:FIELD_W] == q_asn_r)) &&
                  (!q_use_val_r || (rd_data[FIELD_W-1:0] == q_val_r));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    asn_sum_nxt   = asn_sum_r;
    val_sum_nxt   = val_sum_r;
    hash_nxt      = hash_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = fill_r[AW-1:0];
    wr_data       = {req.entry_asn, req.entry_value};
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          res_nxt.found   = 1'b0;
          res_nxt.dropped = 1'b0;
          res_valid_nxt   = 1'b1;
          unique case (req.req_type)
            REQ_CLEAR: begin
              fill_nxt    = '0;
              asn_sum_nxt = '0;
              val_sum_nxt = '0;
              hash_nxt    = '0;
            end
            REQ_INSERT: begin
              if (fill_r == FULL_CNT) begin
                res_nxt.dropped = 1'b1;
              end else begin
                wr_en       = 1'b1;
                fill_nxt    = fill_r + CW'(1);
                asn_sum_nxt = asn_sum_r | req.entry_asn;
                val_sum_nxt = val_sum_r | req.entry_value;
                if (fill_r == '0) begin
                  hash_nxt = mix;
                end else begin
                  hash_nxt = (hash_r << HASH_SHIFT) - hash_r + mix;
                end
              end
            end
            REQ_MATCH: begin
              if (reject || (fill_r == '0)) begin
                res_nxt.found = 1'b0;
              end else if (!req.use_asn && !req.use_value) begin
                res_nxt.found = 1'b1;
              end else begin
                // first read goes out with the accept, result comes from the scan
                res_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = '0;
                idx_nxt       = CW'(1);
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
          res_nxt.entry_count = CNT_OUT_W'(fill_nxt);
          res_nxt.set_hash    = hash_nxt;
        end
      end
      ST_SCAN: begin
        // rd_data holds entry idx_r-1
        if (hit || (idx_r == fill_r)) begin
          res_nxt.found       = hit;
          res_nxt.dropped     = 1'b0;
          res_nxt.entry_count = CNT_OUT_W'(fill_r);
          res_nxt.set_hash    = hash_r;
          res_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      asn_sum_r   <= '0;
      val_sum_r   <= '0;
      hash_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      asn_sum_r   <= asn_sum_nxt;
      val_sum_r   <= val_sum_nxt;
      hash_r      <= hash_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (req_fire) begin
      q_asn_r     <= req.entry_asn;
      q_val_r     <= req.entry_value;
      q_use_asn_r <= req.use_asn;
      q_use_val_r <= req.use_value;
    end
  end

endmodule

`default_nettype wire

// File: design/community_set_masked_match.sv
// Community set masked match: ordered set of BGP communities with summary
// reject and sequential scan.
//
// Channels: in_* carries requests (tuser = request kind, tdata = community
// halves and match selects); out_* carries one result word per request.
// Clear, insert, a summary-rejected match, a match on an empty set and a
// match with no half selected finish in the accept cycle; their result word
// is registered in the sequencer and then in the output register before it
// shows on out_*; while out_tready stays high, a new request can be taken
// every cycle. A scanning match reads one stored entry per cycle from the
// entry RAM, whose single read port sets this rate, and stops at the first
// agreeing entry or after the last stored one; no new request is taken
// while it scans, and its word then passes through the same two registers.
// The sequencer result register and the output register form a two-word
// buffer: while out_tready is low one more request is still taken, then
// in_tready drops until the receiver resumes. No word is lost.
// Reset empties the set (count, summaries and hash go to zero); the entry
// RAM is not cleared, as only entries below the fill count are ever read.
`default_nettype none

`include "community_set_masked_match_defines.svh"

module community_set_masked_match
  import csm_pkg::*;
#(
  parameter int SET_DEPTH = DEF_SET_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] entry_asn, [31:16] entry_value, [32] use_asn, [33] use_value
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] found, [1] dropped, [8:2] entry_count, [40:9] set_hash
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  req_t                 req;
  res_t                 core_res;
  logic                 core_res_valid;
  logic                 core_res_ready;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [2*FIELD_W-1:0] wr_data, rd_data;
  logic                 out_valid_r;
  res_t                 out_res_r;

  assign req.req_type    = in_tuser;
  assign req.entry_asn   = in_tdata[FIELD_W-1:0];
  assign req.entry_value = in_tdata[2*FIELD_W-1:FIELD_W];
  assign req.use_asn     = in_tdata[2*FIELD_W];
  assign req.use_value   = in_tdata[2*FIELD_W+1];

  csm_core #(
    .SET_DEPTH(SET_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  csm_ram #(
    .WIDTH(2*FIELD_W),
    .DEPTH(SET_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign core_res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_r <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_ready && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_res_r.set_hash, out_res_r.entry_count,
                                   out_res_r.dropped, out_res_r.found});

  `CSM_ASSERT_HOLD(a_found_xor_drop, !core_res_valid || !(core_res.found && core_res.dropped),
                   "result flags found and dropped both set")
  `CSM_ASSERT_HOLD(a_drop_when_full,
                   !(core_res_valid && core_res.dropped) ||
                   (core_res.entry_count == CNT_OUT_W'(SET_DEPTH)),
                   "insert dropped while set not full")
  `CSM_ASSERT_HOLD(a_empty_result,
                   !(core_res_valid && (core_res.entry_count == '0)) ||
                   ((core_res.set_hash == '0) && !core_res.found),
                   "empty set reported hash or match")
  `CSM_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, core_res_valid || !in_tready,
                   "accepted word left no result and no busy scan")

endmodule

`default_nettype wire
